/* rtl/core/pcm_pkg.sv */
// Shared constants, register indexes and types of the perspective coordinate map.
`default_nettype none
package pcm_pkg;

  localparam int CoordBits    = 16;
  localparam int CoefFracBits = 32;
  localparam int RegBits      = 48;
  localparam int NumRegs      = 8;
  localparam int RegIdxBits   = $clog2(NumRegs);
  localparam int QuotBits     = 32;
  localparam int OutFrac      = QuotBits - CoordBits;
  localparam int ProdBits     = RegBits + CoordBits;
  localparam int SumBits      = ProdBits + 2;
  localparam int NumBits      = SumBits + OutFrac;
  localparam int HiBits       = NumBits - QuotBits;
  localparam int DataBits     = 64;
  localparam int AddrBits     = RegIdxBits + 3;
  localparam int AlphaBits    = 8;

  localparam logic [AlphaBits-1:0] AlphaOn = {AlphaBits{1'b1}};
  localparam logic [SumBits-1:0]   DenOne  = SumBits'(1) << CoefFracBits;
  localparam logic [RegBits-1:0]   CoefOne = RegBits'(1) << CoefFracBits;

  localparam logic [RegIdxBits-1:0] RegCoefXx  = RegIdxBits'(0);
  localparam logic [RegIdxBits-1:0] RegCoefXy  = RegIdxBits'(1);
  localparam logic [RegIdxBits-1:0] RegOffsetX = RegIdxBits'(2);
  localparam logic [RegIdxBits-1:0] RegCoefYx  = RegIdxBits'(3);
  localparam logic [RegIdxBits-1:0] RegCoefYy  = RegIdxBits'(4);
  localparam logic [RegIdxBits-1:0] RegOffsetY = RegIdxBits'(5);
  localparam logic [RegIdxBits-1:0] RegPerspX  = RegIdxBits'(6);
  localparam logic [RegIdxBits-1:0] RegPerspY  = RegIdxBits'(7);

  typedef logic [NumRegs-1:0][RegBits-1:0] cfg_t;

  typedef struct packed {
    logic                vld;
    logic                sel;
    logic                neg_x;
    logic                neg_y;
    logic                ovf_x;
    logic                ovf_y;
    logic [SumBits-1:0]  den;
    logic [SumBits-1:0]  rem_x;
    logic [SumBits-1:0]  rem_y;
    logic [QuotBits-1:0] lo_x;
    logic [QuotBits-1:0] lo_y;
  } cell_t;

endpackage
`default_nettype wire

/* rtl/core/pcm_if.sv */
// Item channel interfaces: destination pixel in, source coordinate out.
`default_nettype none
interface pcm_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pcm_pkg::CoordBits-1:0] dst_x;
  logic signed [pcm_pkg::CoordBits-1:0] dst_y;
  logic                                selected;
  modport source (output valid, dst_x, dst_y, selected, input ready);
  modport sink (input valid, dst_x, dst_y, selected, output ready);
endinterface

interface pcm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pcm_pkg::QuotBits-1:0]  src_x;
  logic signed [pcm_pkg::QuotBits-1:0]  src_y;
  logic [pcm_pkg::AlphaBits-1:0]        alpha;
  logic                                 sample_valid;
  logic                                 saturated;
  modport source (output valid, src_x, src_y, alpha, sample_valid, saturated, input ready);
  modport sink (input valid, src_x, src_y, alpha, sample_valid, saturated, output ready);
endinterface
`default_nettype wire

/* rtl/core/pcm_cfg.sv */
// APB register file holding the eight warp coefficients.
`default_nettype none
module pcm_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pcm_pkg::AddrBits-1:0]  paddr,
  input  wire logic [pcm_pkg::DataBits-1:0]  pwdata,
  output      logic [pcm_pkg::DataBits-1:0]  prdata,
  output      logic                          pready,
  output      pcm_pkg::cfg_t                 cfg_o
);

  pcm_pkg::cfg_t                  regs_q;
  logic [pcm_pkg::RegIdxBits-1:0] idx;

  assign idx    = paddr[pcm_pkg::AddrBits-1:3];
  assign pready = 1'b1;
  assign prdata = pcm_pkg::DataBits'(regs_q[idx]);
  assign cfg_o  = regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q                     <= '0;
      regs_q[pcm_pkg::RegCoefXx] <= pcm_pkg::CoefOne;
      regs_q[pcm_pkg::RegCoefYy] <= pcm_pkg::CoefOne;
    end else if (psel && penable && pwrite) begin
      regs_q[idx] <= pwdata[pcm_pkg::RegBits-1:0];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/pcm_front.sv */
// Front pipeline: products, sums, magnitudes and overflow check feeding the divider row.
`default_nettype none
module pcm_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                en_i,
  input  wire logic                                vld_i,
  input  wire logic signed [pcm_pkg::CoordBits-1:0] x_i,
  input  wire logic signed [pcm_pkg::CoordBits-1:0] y_i,
  input  wire logic                                sel_i,
  input  wire pcm_pkg::cfg_t                       cfg_i,
  output      pcm_pkg::cell_t                      cell_o
);

  localparam int PB = pcm_pkg::ProdBits;
  localparam int SB = pcm_pkg::SumBits;
  localparam int NB = pcm_pkg::NumBits;
  localparam int QB = pcm_pkg::QuotBits;

  // stage 1: products
  logic                 v1_q, s1_q;
  logic signed [PB-1:0] p_q [6];
  // stage 2: sums
  logic                 v2_q, s2_q;
  logic signed [SB-1:0] nx_q, ny_q, dn_q;
  logic signed [SB-1:0] dsum, nx_d, ny_d, dn_d;
  // stage 3: magnitudes
  logic                 v3_q, s3_q, ngx_q, ngy_q;
  logic [NB-1:0]        mx_q, my_q;
  logic [SB-1:0]        md_q;
  logic [SB-1:0]        ax, ay, ad;
  logic [SB-1:0]        hx, hy;

  function automatic logic signed [PB-1:0] mul(input logic [pcm_pkg::RegBits-1:0] c,
                                               input logic signed [pcm_pkg::CoordBits-1:0] v);
    return PB'($signed(c)) * PB'(v);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q   <= sel_i;
      p_q[0] <= mul(cfg_i[pcm_pkg::RegCoefXx], x_i);
      p_q[1] <= mul(cfg_i[pcm_pkg::RegCoefXy], y_i);
      p_q[2] <= mul(cfg_i[pcm_pkg::RegCoefYx], x_i);
      p_q[3] <= mul(cfg_i[pcm_pkg::RegCoefYy], y_i);
      p_q[4] <= mul(cfg_i[pcm_pkg::RegPerspX], x_i);
      p_q[5] <= mul(cfg_i[pcm_pkg::RegPerspY], y_i);
    end
  end

  always_comb begin
    dsum = SB'(p_q[4]) + SB'(p_q[5]) + $signed(pcm_pkg::DenOne);
    dn_d = (dsum == '0) ? $signed(pcm_pkg::DenOne) : dsum;
    nx_d = SB'(p_q[0]) + SB'(p_q[1]) + SB'($signed(cfg_i[pcm_pkg::RegOffsetX]));
    ny_d = SB'(p_q[2]) + SB'(p_q[3]) + SB'($signed(cfg_i[pcm_pkg::RegOffsetY]));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q <= s1_q;
      nx_q <= nx_d;
      ny_q <= ny_d;
      dn_q <= dn_d;
    end
  end

  always_comb begin
    ax = nx_q[SB-1] ? SB'(-nx_q) : SB'(nx_q);
    ay = ny_q[SB-1] ? SB'(-ny_q) : SB'(ny_q);
    ad = dn_q[SB-1] ? SB'(-dn_q) : SB'(dn_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_q  <= s2_q;
      ngx_q <= nx_q[SB-1] ^ dn_q[SB-1];
      ngy_q <= ny_q[SB-1] ^ dn_q[SB-1];
      mx_q  <= {ax, {pcm_pkg::OutFrac{1'b0}}};
      my_q  <= {ay, {pcm_pkg::OutFrac{1'b0}}};
      md_q  <= ad;
    end
  end

  // quotient fits QB bits only when the upper numerator part is below the divisor
  assign hx = SB'(mx_q[NB-1:QB]);
  assign hy = SB'(my_q[NB-1:QB]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_o <= '0;
    end else if (en_i) begin
      cell_o.vld   <= v3_q;
      cell_o.sel   <= s3_q;
      cell_o.neg_x <= ngx_q;
      cell_o.neg_y <= ngy_q;
      cell_o.ovf_x <= hx >= md_q;
      cell_o.ovf_y <= hy >= md_q;
      cell_o.den   <= md_q;
      cell_o.rem_x <= hx;
      cell_o.rem_y <= hy;
      cell_o.lo_x  <= mx_q[QB-1:0];
      cell_o.lo_y  <= my_q[QB-1:0];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/pcm_cell.sv */
// One restoring division step for both coordinates, registered.
`default_nettype none
module pcm_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire pcm_pkg::cell_t cell_i,
  output      pcm_pkg::cell_t cell_o
);

  localparam int SB = pcm_pkg::SumBits;
  localparam int QB = pcm_pkg::QuotBits;

  logic [SB:0] tx, ty;
  logic        bx, by;

  always_comb begin
    tx = {cell_i.rem_x, cell_i.lo_x[QB-1]} - {1'b0, cell_i.den};
    ty = {cell_i.rem_y, cell_i.lo_y[QB-1]} - {1'b0, cell_i.den};
    bx = !tx[SB] || cell_i.rem_x[SB-1];
    by = !ty[SB] || cell_i.rem_y[SB-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_o <= '0;
    end else if (en_i) begin
      cell_o.vld   <= cell_i.vld;
      cell_o.sel   <= cell_i.sel;
      cell_o.neg_x <= cell_i.neg_x;
      cell_o.neg_y <= cell_i.neg_y;
      cell_o.ovf_x <= cell_i.ovf_x;
      cell_o.ovf_y <= cell_i.ovf_y;
      cell_o.den   <= cell_i.den;
      cell_o.rem_x <= bx ? tx[SB-1:0] : {cell_i.rem_x[SB-2:0], cell_i.lo_x[QB-1]};
      cell_o.rem_y <= by ? ty[SB-1:0] : {cell_i.rem_y[SB-2:0], cell_i.lo_y[QB-1]};
      cell_o.lo_x  <= {cell_i.lo_x[QB-2:0], bx};
      cell_o.lo_y  <= {cell_i.lo_y[QB-2:0], by};
    end
  end

endmodule
`default_nettype wire

/* rtl/core/perspective_coordinate_map_top.sv */
// Top level of the perspective coordinate map.
// Maps each destination pixel to its source coordinate through a projective
// transform and accepts one item per clock unless the output stalls. It has three
// multiply/sum/magnitude stages, an overflow-check stage, a row of 32 division
// cells (one quotient bit each, both coordinates) and the output register.
// The whole pipeline advances whenever the output register is empty or taken.
// Registers sit at 8-byte strides on the APB port; write them only while idle.
`default_nettype none
module perspective_coordinate_map_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pcm_pkg::AddrBits-1:0]  paddr,
  input  wire logic [pcm_pkg::DataBits-1:0]  pwdata,
  output      logic [pcm_pkg::DataBits-1:0]  prdata,
  output      logic                          pready,
  pcm_in_if.sink                             in_i,
  pcm_out_if.source                          out_o
);

  localparam int QB = pcm_pkg::QuotBits;

  pcm_pkg::cfg_t  cfg;
  pcm_pkg::cell_t chain [QB+1];
  pcm_pkg::cell_t c;
  logic           en;
  logic [QB-1:0]  lim_x, lim_y, r_x, r_y;
  logic           sat_x, sat_y;

  logic                 vld_q, sel_q, sat_q;
  logic signed [QB-1:0] sx_q, sy_q;

  assign en = !vld_q || out_o.ready;
  assign in_i.ready = en;

  pcm_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  pcm_front u_front (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_i.valid), .x_i(in_i.dst_x), .y_i(in_i.dst_y),
    .sel_i(in_i.selected), .cfg_i(cfg), .cell_o(chain[0])
  );

  for (genvar g = 0; g < QB; g++) begin : g_cell
    pcm_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .cell_i(chain[g]), .cell_o(chain[g+1])
    );
  end

  assign c = chain[QB];

  always_comb begin
    lim_x = c.neg_x ? {1'b1, {(QB-1){1'b0}}} : {1'b0, {(QB-1){1'b1}}};
    lim_y = c.neg_y ? {1'b1, {(QB-1){1'b0}}} : {1'b0, {(QB-1){1'b1}}};
    sat_x = c.ovf_x || (c.lo_x > lim_x);
    sat_y = c.ovf_y || (c.lo_y > lim_y);
    r_x   = sat_x ? lim_x : c.lo_x;
    r_y   = sat_y ? lim_y : c.lo_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= c.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sel_q <= c.sel;
      sat_q <= c.sel && (sat_x || sat_y);
      sx_q  <= !c.sel ? '0 : (c.neg_x ? -r_x : r_x);
      sy_q  <= !c.sel ? '0 : (c.neg_y ? -r_y : r_y);
    end
  end

  assign out_o.valid        = vld_q;
  assign out_o.src_x        = sx_q;
  assign out_o.src_y        = sy_q;
  assign out_o.alpha        = sel_q ? pcm_pkg::AlphaOn : '0;
  assign out_o.sample_valid = sel_q;
  assign out_o.saturated    = sat_q;

  a_unsel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && !sel_q |-> sx_q == '0 && sy_q == '0 && !sat_q)
    else $error("unselected item with nonzero result");

  a_sat_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sat_q |-> sel_q)
    else $error("saturation on unselected item");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && !out_o.ready |=> vld_q && $stable(sx_q) && $stable(sy_q))
    else $error("output register changed while stalled");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && chain[QB].vld |=> vld_q)
    else $error("finished item lost at output register");

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for the perspective coordinate map: random warps, pixels and stalls.
`timescale 1ns / 1ps
`default_nettype none
module tb;

  typedef struct packed {
    logic [pcm_pkg::QuotBits-1:0]  src_x;
    logic [pcm_pkg::QuotBits-1:0]  src_y;
    logic [pcm_pkg::AlphaBits-1:0] alpha;
    logic                          sample_valid;
    logic                          saturated;
  } coord_t;

  class coord_board;
    logic signed [pcm_pkg::RegBits-1:0] warp [pcm_pkg::NumRegs];
    coord_t pending[$];
    int     errors;
    int     shown;

    function new();
      foreach (warp[i]) warp[i] = '0;
      warp[pcm_pkg::RegCoefXx] = pcm_pkg::CoefOne;
      warp[pcm_pkg::RegCoefYy] = pcm_pkg::CoefOne;
      errors = 0;
      shown = 0;
    endfunction

    function automatic logic [pcm_pkg::QuotBits-1:0] div_sat(logic signed [127:0] num,
                                                             logic signed [127:0] den,
                                                             ref logic sat);
      logic [127:0] nm;
      logic [127:0] dm;
      logic [127:0] q;
      logic         neg;
      logic [127:0] lim;
      neg = num[127] ^ den[127];
      nm = num[127] ? -num : num;
      dm = den[127] ? -den : den;
      q = (nm << pcm_pkg::OutFrac) / dm;
      lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (q > lim) begin
        sat = 1'b1;
        q = lim;
      end
      return neg ? pcm_pkg::QuotBits'(-q) : pcm_pkg::QuotBits'(q);
    endfunction

    function void note_pixel(logic signed [pcm_pkg::CoordBits-1:0] x,
                             logic signed [pcm_pkg::CoordBits-1:0] y,
                             logic sel);
      logic signed [127:0] den;
      logic signed [127:0] nx;
      logic signed [127:0] ny;
      logic signed [127:0] one;
      logic                sat;
      coord_t              c;
      c = '0;
      if (sel) begin
        sat = 1'b0;
        one = 128'sd1 << pcm_pkg::CoefFracBits;
        den = 128'(warp[pcm_pkg::RegPerspX]) * 128'(x)
              + 128'(warp[pcm_pkg::RegPerspY]) * 128'(y) + one;
        if (den == 0) den = one;
        nx = 128'(warp[pcm_pkg::RegCoefXx]) * 128'(x) + 128'(warp[pcm_pkg::RegCoefXy]) * 128'(y)
             + 128'(warp[pcm_pkg::RegOffsetX]);
        ny = 128'(warp[pcm_pkg::RegCoefYx]) * 128'(x) + 128'(warp[pcm_pkg::RegCoefYy]) * 128'(y)
             + 128'(warp[pcm_pkg::RegOffsetY]);
        c.src_x = div_sat(nx, den, sat);
        c.src_y = div_sat(ny, den, sat);
        c.alpha = pcm_pkg::AlphaOn;
        c.sample_valid = 1'b1;
        c.saturated = sat;
      end
      pending.push_back(c);
    endfunction

    function void check_coord(coord_t got);
      coord_t exp_c;
      if (pending.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected item %h", got);
        end
        return;
      end
      exp_c = pending.pop_front();
      if (got !== exp_c) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("exp x=%h y=%h a=%h v=%b s=%b got x=%h y=%h a=%h v=%b s=%b",
                   exp_c.src_x, exp_c.src_y, exp_c.alpha, exp_c.sample_valid,
                   exp_c.saturated, got.src_x, got.src_y, got.alpha, got.sample_valid,
                   got.saturated);
        end
      end
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [pcm_pkg::AddrBits-1:0] paddr;
  logic [pcm_pkg::DataBits-1:0] pwdata;
  logic [pcm_pkg::DataBits-1:0] prdata;
  logic                         pready;
  int                           send_idle;
  int                           recv_idle;
  longint                       cycles;
  coord_board                   board;

  pcm_in_if  in_if ();
  pcm_out_if out_if ();

  perspective_coordinate_map_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_if.sink),
    .out_o   (out_if.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    board = new();
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.dst_x = '0;
    in_if.dst_y = '0;
    in_if.selected = 1'b0;
    out_if.ready = 1'b0;
    send_idle = 0;
    recv_idle = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (in_if.valid && in_if.ready)
      board.note_pixel(in_if.dst_x, in_if.dst_y, in_if.selected);
    if (out_if.valid && out_if.ready)
      board.check_coord({out_if.src_x, out_if.src_y, out_if.alpha, out_if.sample_valid,
                         out_if.saturated});
    out_if.ready <= ($urandom_range(99) >= recv_idle);
  end

  initial begin
    cycles = 0;
    wait (cycles > 64'd3_000_000);
    $display("perspective_coordinate_map_top: mismatch");
    $finish;
  end

  task automatic write_reg(logic [pcm_pkg::RegIdxBits-1:0] idx,
                           logic [pcm_pkg::RegBits-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= pcm_pkg::AddrBits'(idx) << 3;
    pwdata <= pcm_pkg::DataBits'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.warp[idx] = val;
  endtask

  // valid stays up after an accepted item; an idle cycle or drain() drops it
  task automatic send_pixel(logic [pcm_pkg::CoordBits-1:0] x,
                            logic [pcm_pkg::CoordBits-1:0] y, logic sel);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.dst_x <= x;
    in_if.dst_y <= y;
    in_if.selected <= sel;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic [pcm_pkg::CoordBits-1:0] rand_coord();
    case ($urandom_range(3))
      0: return pcm_pkg::CoordBits'($urandom_range(15));
      1: return -pcm_pkg::CoordBits'($urandom_range(15));
      2: return pcm_pkg::CoordBits'($urandom_range(2047));
      default: return pcm_pkg::CoordBits'($urandom);
    endcase
  endfunction

  function automatic logic [pcm_pkg::RegBits-1:0] rand_coef();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(5))
      0: return pcm_pkg::RegBits'(64'sd1 <<< 47);
      1: return {1'b0, {(pcm_pkg::RegBits-1){1'b1}}};
      2: return pcm_pkg::RegBits'(r);
      3: return pcm_pkg::RegBits'($signed(r[35:0]));
      4: return pcm_pkg::RegBits'($signed(r[27:0]));
      default: return '0;
    endcase
  endfunction

  task automatic run_phase(int n);
    repeat (n) send_pixel(rand_coord(), rand_coord(), $urandom_range(9) != 0);
  endtask

  initial begin
    logic [pcm_pkg::CoordBits-1:0] ext [4];
    ext[0] = 16'h8000;
    ext[1] = 16'h7FFF;
    ext[2] = 16'h0000;
    ext[3] = 16'hFFFF;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle = 28;
    recv_idle = 58;
    // identity map
    foreach (ext[i]) send_pixel(ext[i], ext[3 - i], 1'b1);
    send_pixel(16'h1234, 16'hABCD, 1'b0);
    send_pixel(16'h0005, 16'h0007, 1'b1);
    drain();
    // zero denominator: px = -1, at x = 1
    write_reg(pcm_pkg::RegPerspX, -pcm_pkg::CoefOne);
    write_reg(pcm_pkg::RegOffsetX, pcm_pkg::RegBits'(48'sh7FFF_FFFF_FFFF));
    write_reg(pcm_pkg::RegOffsetY, pcm_pkg::RegBits'(48'sh8000_0000_0000));
    send_pixel(16'h0001, 16'h0000, 1'b1);
    send_pixel(16'h0002, 16'h0003, 1'b1);
    send_pixel(16'h7FFF, 16'h8000, 1'b1);
    send_pixel(16'h8000, 16'h7FFF, 1'b1);
    drain();
    for (int i = 0; i < pcm_pkg::NumRegs; i++)
      write_reg(pcm_pkg::RegIdxBits'(i), {1'b1, {(pcm_pkg::RegBits-1){1'b0}}});
    foreach (ext[i]) send_pixel(ext[i], ext[i], 1'b1);
    drain();
    for (int i = 0; i < pcm_pkg::NumRegs; i++)
      write_reg(pcm_pkg::RegIdxBits'(i), {1'b0, {(pcm_pkg::RegBits-1){1'b1}}});
    foreach (ext[i]) send_pixel(ext[i], ext[(i + 1) % 4], 1'b1);
    drain();
    for (int ph = 0; ph < 15; ph++) begin
      if (ph == 5) begin
        send_idle = 58;
        recv_idle = 28;
      end else if (ph == 10) begin
        send_idle = 0;
        recv_idle = 0;
      end
      for (int i = 0; i < pcm_pkg::NumRegs; i++)
        write_reg(pcm_pkg::RegIdxBits'(i), rand_coef());
      if ($urandom_range(1)) write_reg(pcm_pkg::RegPerspX, '0);
      if ($urandom_range(1)) write_reg(pcm_pkg::RegPerspY, '0);
      run_phase(100);
      drain();
    end
    if (board.errors == 0) begin
      $display("perspective_coordinate_map_top: match");
    end else begin
      $display("perspective_coordinate_map_top: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire
